@@ src/dsct_pkg.sv @@
// dsct_pkg: widths, register indexes, channel state type and led duty table
// for the dual sensor change timer; no dependencies
package dsct_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int TIME_BITS   = 32;
  localparam int THR_BITS    = 12;
  localparam int MS_BITS     = 16;
  localparam int CFG_BITS    = 16;
  localparam int CMP_BITS    = 16;
  localparam int DUTY_BITS   = 8;

  localparam logic [THR_BITS-1:0] THR_RESET      = THR_BITS'(50);
  localparam logic [MS_BITS-1:0]  HOLDOFF_RESET  = MS_BITS'(100);
  localparam logic [MS_BITS-1:0]  INTERVAL_RESET = MS_BITS'(100);

  localparam logic [DUTY_BITS-1:0] DUTY_OFF  = DUTY_BITS'(0);
  localparam logic [DUTY_BITS-1:0] DUTY_LOW  = DUTY_BITS'(85);
  localparam logic [DUTY_BITS-1:0] DUTY_HIGH = DUTY_BITS'(170);
  localparam logic [DUTY_BITS-1:0] DUTY_FULL = DUTY_BITS'(255);

  typedef enum logic [1:0] {
    REG_THR_ONE  = 2'd0,
    REG_THR_TWO  = 2'd1,
    REG_HOLDOFF  = 2'd2,
    REG_INTERVAL = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LEAD_NONE = 2'd0,
    LEAD_ONE  = 2'd1,
    LEAD_TWO  = 2'd2
  } lead_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] value;
    logic [TIME_BITS-1:0]   stamp;
  } chan_st_t;

  // four levels from the top two bits of the stored sample
  function automatic logic [DUTY_BITS-1:0] duty_of(input logic [1:0] level);
    logic [DUTY_BITS-1:0] d;
    case (level)
      2'd0:    d = DUTY_OFF;
      2'd1:    d = DUTY_LOW;
      2'd2:    d = DUTY_HIGH;
      default: d = DUTY_FULL;
    endcase
    return d;
  endfunction

endpackage

@@ src/dsct_chan.sv @@
// dsct_chan: holdoff and threshold test for one sensor channel, with its
// next stored value and change time; depends on dsct_pkg
module dsct_chan (
  input  dsct_pkg::chan_st_t                 st,
  input  logic [dsct_pkg::SAMPLE_BITS-1:0]   sample,
  input  logic [dsct_pkg::TIME_BITS-1:0]     now_ms,
  input  logic [dsct_pkg::THR_BITS-1:0]      threshold,
  input  logic [dsct_pkg::MS_BITS-1:0]       holdoff_ms,
  output logic                               accept,
  output dsct_pkg::chan_st_t                 st_nxt
);
  import dsct_pkg::*;

  logic [TIME_BITS-1:0]   since;
  logic [SAMPLE_BITS-1:0] diff;

  always_comb begin
    since  = now_ms - st.stamp;
    diff   = (sample >= st.value) ? (sample - st.value) : (st.value - sample);
    accept = (since >= TIME_BITS'(holdoff_ms)) &&
             (CMP_BITS'(diff) >= CMP_BITS'(threshold));
    st_nxt = st;
    if (accept) begin
      st_nxt.value = sample;
      st_nxt.stamp = now_ms;
    end
  end

endmodule

@@ src/dual_sensor_change_timer.sv @@
// dual_sensor_change_timer: top level with input register, per-item update
// of channel state and the result register; depends on dsct_pkg, dsct_chan
// an item waits in the input register and moves into the result register when it fires
// throughput: one item per cycle while out_stall is low; the input register holds one more item
//   while a result waits on out_stall
// reset (rst_n low, synchronous): channel state, leader, gap and report time
//   clear to zero, registers return to 50/50/100/100, both stages empty
module dual_sensor_change_timer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [dsct_pkg::CFG_BITS-1:0]      cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dsct_pkg::SAMPLE_BITS-1:0]   in_sample_one,
  input  logic [dsct_pkg::SAMPLE_BITS-1:0]   in_sample_two,
  input  logic [dsct_pkg::TIME_BITS-1:0]     in_now_ms,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [dsct_pkg::SAMPLE_BITS-1:0]   out_held_one,
  output logic [dsct_pkg::SAMPLE_BITS-1:0]   out_held_two,
  output logic                               out_changed_one,
  output logic                               out_changed_two,
  output logic [1:0]                         out_leader,
  output logic [dsct_pkg::TIME_BITS-1:0]     out_response_ms,
  output logic                               out_report,
  output logic [dsct_pkg::DUTY_BITS-1:0]     out_led_duty
);
  import dsct_pkg::*;

  // configuration
  logic [THR_BITS-1:0] thr_one_r, thr_two_r;
  logic [MS_BITS-1:0]  holdoff_r, interval_r;

  // input stage
  logic                   in_valid_r;
  logic [SAMPLE_BITS-1:0] s1_r, s2_r;
  logic [TIME_BITS-1:0]   now_r;

  // block state
  chan_st_t             ch1_r, ch2_r;
  lead_t                last_r;
  logic [TIME_BITS-1:0] gap_r, rep_time_r;

  chan_st_t             ch1_nxt, ch2_nxt;
  lead_t                last_nxt, last_mid;
  logic [TIME_BITS-1:0] gap_nxt, rep_time_nxt;
  logic                 acc1, acc2, rep;

  // result stage
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] held_one_r, held_two_r;
  logic                   chg_one_r, chg_two_r, report_r;
  lead_t                  leader_r;
  logic [TIME_BITS-1:0]   resp_r;
  logic [DUTY_BITS-1:0]   duty_r;

  logic out_adv, fire;

  assign out_adv  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && out_adv;
  assign in_stall = in_valid_r && !out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_one_r  <= THR_RESET;
      thr_two_r  <= THR_RESET;
      holdoff_r  <= HOLDOFF_RESET;
      interval_r <= INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_THR_ONE:  thr_one_r  <= cfg_data[THR_BITS-1:0];
        REG_THR_TWO:  thr_two_r  <= cfg_data[THR_BITS-1:0];
        REG_HOLDOFF:  holdoff_r  <= cfg_data[MS_BITS-1:0];
        REG_INTERVAL: interval_r <= cfg_data[MS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r  <= in_sample_one;
      s2_r  <= in_sample_two;
      now_r <= in_now_ms;
    end
  end

  dsct_chan u_chan_one (
    .st         (ch1_r),
    .sample     (s1_r),
    .now_ms     (now_r),
    .threshold  (thr_one_r),
    .holdoff_ms (holdoff_r),
    .accept     (acc1),
    .st_nxt     (ch1_nxt)
  );

  dsct_chan u_chan_two (
    .st         (ch2_r),
    .sample     (s2_r),
    .now_ms     (now_r),
    .threshold  (thr_two_r),
    .holdoff_ms (holdoff_r),
    .accept     (acc2),
    .st_nxt     (ch2_nxt)
  );

  // channel two sees channel one's change of the same item
  always_comb begin
    gap_nxt  = gap_r;
    last_mid = last_r;
    if (acc1) begin
      gap_nxt  = (last_r == LEAD_TWO) ? (now_r - ch2_r.stamp) : '0;
      last_mid = LEAD_ONE;
    end
    last_nxt = last_mid;
    if (acc2) begin
      gap_nxt  = (last_mid == LEAD_ONE) ? (now_r - ch1_nxt.stamp) : '0;
      last_nxt = LEAD_TWO;
    end
    rep          = acc1 || acc2 || ((now_r - rep_time_r) >= TIME_BITS'(interval_r));
    rep_time_nxt = rep ? now_r : rep_time_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch1_r      <= '0;
      ch2_r      <= '0;
      last_r     <= LEAD_NONE;
      gap_r      <= '0;
      rep_time_r <= '0;
    end else if (fire) begin
      ch1_r      <= ch1_nxt;
      ch2_r      <= ch2_nxt;
      last_r     <= last_nxt;
      gap_r      <= gap_nxt;
      rep_time_r <= rep_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held_one_r <= ch1_nxt.value;
      held_two_r <= ch2_nxt.value;
      chg_one_r  <= acc1;
      chg_two_r  <= acc2;
      leader_r   <= last_nxt;
      resp_r     <= gap_nxt;
      report_r   <= rep;
      duty_r     <= duty_of(ch1_nxt.value[SAMPLE_BITS-1 -: 2]);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_held_one    = held_one_r;
  assign out_held_two    = held_two_r;
  assign out_changed_one = chg_one_r;
  assign out_changed_two = chg_two_r;
  assign out_leader      = leader_r;
  assign out_response_ms = resp_r;
  assign out_report      = report_r;
  assign out_led_duty    = duty_r;

  a_change_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (chg_one_r || chg_two_r)) |-> report_r)
    else $error("change transfer without report");

  a_none_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && leader_r == LEAD_NONE) |->
      (resp_r == '0 && !chg_one_r && !chg_two_r))
    else $error("response or change with no leader");

  a_both_zero_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && chg_one_r && chg_two_r) |->
      (resp_r == '0 && leader_r == LEAD_TWO))
    else $error("same item change on both channels gives wrong gap or leader");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_adv) |=> (in_valid_r && $stable(now_r) && $stable(s1_r)))
    else $error("held input item lost while result stalled");

  a_state_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> ($stable(ch1_r) && $stable(ch2_r) && $stable(rep_time_r)))
    else $error("channel state changed without a transfer");

endmodule
